### rtl/lvn_pkg.sv
// Shared types and constants for the lattice value noise block.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package lvn_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_EVAL  = 2'd2;

  // Input tdata layout, lowest bit first
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 16;
  localparam int IDX_LSB     = 0;
  localparam int VAL_LSB     = 8;
  localparam int DIM_LSB     = 24;
  localparam int X_LSB       = 26;
  localparam int COORD_W     = 32;

  // Coordinate selects
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  // Datapath operations
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE = 4'd0;
  localparam dp_op_t OP_LOAD = 4'd1;  // write one value table entry
  localparam dp_op_t OP_TAKE = 4'd2;  // latch coordinates
  localparam dp_op_t OP_FILL = 4'd3;  // identity fill of the permutation
  localparam dp_op_t OP_BRV  = 4'd4;  // build: read value[n]
  localparam dp_op_t OP_BMS  = 4'd5;  // build: scale to swap index
  localparam dp_op_t OP_BRP  = 4'd6;  // build: read perm[n] and perm[s]
  localparam dp_op_t OP_BW1  = 4'd7;  // build: perm[n] <= old perm[s]
  localparam dp_op_t OP_BW2  = 4'd8;  // build: perm[s] <= old perm[n]
  localparam dp_op_t OP_PISS = 4'd9;  // hash read issue
  localparam dp_op_t OP_PCAP = 4'd10; // hash read capture
  localparam dp_op_t OP_VISS = 4'd11; // corner value read issue
  localparam dp_op_t OP_VCAP = 4'd12; // corner value capture
  localparam dp_op_t OP_PEND = 4'd13; // park lower corner of a level
  localparam dp_op_t OP_BMUL = 4'd14; // blend multiply
  localparam dp_op_t OP_BADD = 4'd15; // blend add

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;      // coordinate for a hash read
    logic       add_h;    // add previous hash to the lattice coordinate
    logic       to_save;  // hash capture goes to the saved hash
    logic       clr_save; // start of a corner
    logic [2:0] cbit;     // corner offsets, x in bit 0
    logic [1:0] lev;      // blend level (dimension index)
    logic       cnt_clr;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_stat_t;

endpackage

### rtl/lvn_ctrl.sv
// Controller state machine of the lattice value noise block.
// Sequences loads, permutation builds and evaluations; depends on lvn_pkg.
module lvn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         req,
  input  logic [1:0]         dims_in,
  output logic               out_tvalid,
  input  logic               out_tready,
  output lvn_pkg::dp_cmd_t   cmd,
  input  lvn_pkg::dp_stat_t  stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_BRV   = 4'd2;
  localparam logic [3:0] S_BMS   = 4'd3;
  localparam logic [3:0] S_BRP   = 4'd4;
  localparam logic [3:0] S_BW1   = 4'd5;
  localparam logic [3:0] S_BW2   = 4'd6;
  localparam logic [3:0] S_EISS  = 4'd7;
  localparam logic [3:0] S_ECAP  = 4'd8;
  localparam logic [3:0] S_ELEV  = 4'd9;
  localparam logic [3:0] S_EBLA  = 4'd10;
  localparam logic [3:0] S_EDONE = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] dims_r, dims_nxt;
  logic [2:0] ccnt_r, ccnt_nxt;
  logic [1:0] sidx_r, sidx_nxt;
  logic [1:0] lev_r, lev_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] cbit;
  logic       is_val;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign is_val     = (sidx_r == dims_r);

  // corner offsets per dimension; the last dimension varies fastest
  always_comb begin
    cbit = 3'b000;
    case (dims_r)
      2'd3:    cbit = {ccnt_r[0], ccnt_r[1], ccnt_r[2]};
      2'd2:    cbit = {1'b0, ccnt_r[0], ccnt_r[1]};
      default: cbit = {2'b00, ccnt_r[0]};
    endcase
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    dims_nxt      = dims_r;
    ccnt_nxt      = ccnt_r;
    sidx_nxt      = sidx_r;
    lev_nxt       = lev_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.sel       = dims_r - 2'd1 - sidx_r;
    cmd.add_h     = (sidx_r == 2'd1);
    cmd.to_save   = (dims_r == 2'd3) && (sidx_r == 2'd1);
    cmd.clr_save  = (sidx_r == 2'd0);
    cmd.cbit      = cbit;
    cmd.lev       = lev_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (req)
            lvn_pkg::REQ_LOAD: cmd.op = lvn_pkg::OP_LOAD;
            lvn_pkg::REQ_BUILD: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_FILL;
            end
            lvn_pkg::REQ_EVAL: begin
              cmd.op    = lvn_pkg::OP_TAKE;
              dims_nxt  = (dims_in == 2'd0) ? 2'd1 : dims_in;
              ccnt_nxt  = 3'd0;
              sidx_nxt  = 2'd0;
              state_nxt = S_EISS;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd.op = lvn_pkg::OP_FILL;
        if (stat.cnt_last) state_nxt = S_BRV;
      end
      S_BRV: begin
        cmd.op    = lvn_pkg::OP_BRV;
        state_nxt = S_BMS;
      end
      S_BMS: begin
        cmd.op    = lvn_pkg::OP_BMS;
        state_nxt = S_BRP;
      end
      S_BRP: begin
        cmd.op    = lvn_pkg::OP_BRP;
        state_nxt = S_BW1;
      end
      S_BW1: begin
        cmd.op    = lvn_pkg::OP_BW1;
        state_nxt = S_BW2;
      end
      S_BW2: begin
        cmd.op    = lvn_pkg::OP_BW2;
        state_nxt = stat.cnt_last ? S_IDLE : S_BRV;
      end
      S_EISS: begin
        cmd.op    = is_val ? lvn_pkg::OP_VISS : lvn_pkg::OP_PISS;
        state_nxt = S_ECAP;
      end
      S_ECAP: begin
        if (is_val) begin
          cmd.op    = lvn_pkg::OP_VCAP;
          lev_nxt   = dims_r - 2'd1;
          state_nxt = S_ELEV;
        end else begin
          cmd.op    = lvn_pkg::OP_PCAP;
          sidx_nxt  = sidx_r + 2'd1;
          state_nxt = S_EISS;
        end
      end
      S_ELEV: begin
        // lower corner of this level waits; upper corner blends
        if (!cbit[lev_r]) begin
          cmd.op    = lvn_pkg::OP_PEND;
          ccnt_nxt  = ccnt_r + 3'd1;
          sidx_nxt  = 2'd0;
          state_nxt = S_EISS;
        end else begin
          cmd.op    = lvn_pkg::OP_BMUL;
          state_nxt = S_EBLA;
        end
      end
      S_EBLA: begin
        cmd.op = lvn_pkg::OP_BADD;
        if (lev_r == 2'd0) begin
          state_nxt = S_EDONE;
        end else begin
          lev_nxt   = lev_r - 2'd1;
          state_nxt = S_ELEV;
        end
      end
      S_EDONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dims_r      <= 2'd1;
      ccnt_r      <= 3'd0;
      sidx_r      <= 2'd0;
      lev_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dims_r      <= dims_nxt;
      ccnt_r      <= ccnt_nxt;
      sidx_r      <= sidx_nxt;
      lev_r       <= lev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/lvn_dpath.sv
// Datapath of the lattice value noise block: value and permutation memories,
// coordinate split, weight pipeline, hashing and blend unit. Uses lvn_pkg.
module lvn_dpath #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  lvn_pkg::dp_cmd_t                    cmd,
  output lvn_pkg::dp_stat_t                   stat,
  input  logic [lvn_pkg::IN_TDATA_W-1:0]      in_data,
  output logic [lvn_pkg::OUT_TDATA_W-1:0]     out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int FB    = COORD_FRAC_BITS;
  localparam int IPW   = lvn_pkg::COORD_W - FB;
  localparam int LW    = ((IPW > IDX_W) ? IPW : IDX_W) + 2;

  // memories
  logic [15:0]      vmem [TABLE_ENTRIES];
  logic [IDX_W-1:0] pmem [TABLE_ENTRIES];
  logic [15:0]      vrd_r;
  logic [IDX_W-1:0] pa_r, pb_r;

  // state
  logic signed [IPW-1:0] ip_r [3];
  logic [15:0]           t_r  [3];
  logic [15:0]           t2_r [3];
  logic [15:0]           t3_r [3];
  logic [16:0]           w_r  [3];
  logic [15:0]           pend_r [3];
  logic [IDX_W-1:0]      n_r, s_r, hreg_r, hsave_r;
  logic [15:0]           cur_r, out_r;
  logic signed [34:0]    prod_r;

  // combinational helpers
  logic [IDX_W+7:0]      idx_ext;
  logic                  idx_ok;
  logic signed [IPW-1:0] ip_sel;
  logic signed [LW-1:0]  lat, lat_abs;
  logic [IDX_W-1:0]      hash_addr, vsum;
  logic [IDX_W+15:0]     scaled;
  logic signed [16:0]    diff;
  logic signed [34:0]    bsum;

  assign stat.cnt_last = (n_r == IDX_W'(TABLE_ENTRIES - 1));
  assign out_data      = out_r;

  // load index range check
  assign idx_ext = {{IDX_W{1'b0}}, in_data[lvn_pkg::IDX_LSB +: 8]};
  assign idx_ok  = (idx_ext < (IDX_W + 8)'(TABLE_ENTRIES));

  // lattice coordinate of the addressed corner, then |i| mod table size
  always_comb begin
    case (cmd.sel)
      lvn_pkg::SEL_Y: ip_sel = ip_r[1];
      lvn_pkg::SEL_Z: ip_sel = ip_r[2];
      default:        ip_sel = ip_r[0];
    endcase
    lat = LW'(ip_sel) + $signed(LW'(cmd.cbit[cmd.sel]))
        + (cmd.add_h ? $signed(LW'(hreg_r)) : $signed(LW'(0)));
    lat_abs   = lat[LW-1] ? -lat : lat;
    hash_addr = lat_abs[IDX_W-1:0];
  end

  assign vsum   = hreg_r + hsave_r;
  assign scaled = vrd_r * (IDX_W)'(TABLE_ENTRIES - 1);
  assign diff   = $signed({1'b0, pend_r[cmd.lev]}) - $signed({1'b0, cur_r});
  assign bsum   = $signed({19'd0, cur_r}) + (prod_r >>> 16);

  // weight pipeline: t^2, t^3, then 1 + 2t^3 - 3t^2 clamped
  always_ff @(posedge clk) begin
    logic [31:0]        sq;
    logic [31:0]        cu;
    logic signed [18:0] ws;
    for (int c = 0; c < 3; c++) begin
      sq = t_r[c] * t_r[c];
      cu = t2_r[c] * t_r[c];
      ws = 19'sd65536 + $signed({2'b00, t3_r[c], 1'b0})
         - $signed({2'b00, t2_r[c], 1'b0}) - $signed({3'b000, t2_r[c]});
      t2_r[c] <= sq[31:16];
      t3_r[c] <= cu[31:16];
      if (ws < 0)                 w_r[c] <= 17'd0;
      else if (ws > 19'sd65536)   w_r[c] <= 17'h10000;
      else                        w_r[c] <= ws[16:0];
    end
  end

  // value table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == lvn_pkg::OP_LOAD && idx_ok)
      vmem[idx_ext[IDX_W-1:0]] <= in_data[lvn_pkg::VAL_LSB +: 16];
    if (cmd.op == lvn_pkg::OP_BRV)
      vrd_r <= vmem[n_r];
    else if (cmd.op == lvn_pkg::OP_VISS)
      vrd_r <= vmem[vsum];
  end

  // permutation table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    case (cmd.op)
      lvn_pkg::OP_FILL: pmem[n_r] <= n_r;
      lvn_pkg::OP_BW1:  pmem[n_r] <= pb_r;
      lvn_pkg::OP_BW2:  pmem[s_r] <= pa_r;
      default: ;
    endcase
    if (cmd.op == lvn_pkg::OP_BRP) begin
      pa_r <= pmem[n_r];
      pb_r <= pmem[s_r];
    end else if (cmd.op == lvn_pkg::OP_PISS) begin
      pa_r <= pmem[hash_addr];
    end
  end

  // sequenced datapath registers
  always_ff @(posedge clk) begin
    logic signed [31:0] raw;
    logic [FB+15:0]     fr;
    if (cmd.cnt_clr) n_r <= '0;
    if (cmd.out_load) out_r <= cur_r;
    unique case (cmd.op)
      lvn_pkg::OP_TAKE: begin
        for (int c = 0; c < 3; c++) begin
          raw     = $signed(in_data[lvn_pkg::X_LSB + lvn_pkg::COORD_W*c +: 32]);
          fr      = {raw[FB-1:0], 16'd0} >> FB;
          ip_r[c] <= IPW'(raw >>> FB);
          t_r[c]  <= fr[15:0];
        end
      end
      lvn_pkg::OP_FILL: n_r <= n_r + 1'b1;
      lvn_pkg::OP_BMS:  s_r <= scaled[IDX_W+15:16];
      lvn_pkg::OP_BW2:  n_r <= n_r + 1'b1;
      lvn_pkg::OP_PISS: if (cmd.clr_save) hsave_r <= '0;
      lvn_pkg::OP_PCAP: begin
        if (cmd.to_save) hsave_r <= pa_r;
        else             hreg_r  <= pa_r;
      end
      lvn_pkg::OP_VCAP: cur_r <= vrd_r;
      lvn_pkg::OP_PEND: pend_r[cmd.lev] <= cur_r;
      lvn_pkg::OP_BMUL: prod_r <= diff * $signed({1'b0, w_r[cmd.lev]});
      lvn_pkg::OP_BADD: cur_r <= bsum[15:0];
      default: ;
    endcase
  end

endmodule

### rtl/lattice_value_noise.sv
// Top level of the lattice value noise block.
// Joins lvn_ctrl and lvn_dpath; uses lvn_pkg.
//
// Lattice value noise over a power-of-two table (TABLE_ENTRIES). One request
// is taken at a time; in_tready is high only while the block is idle, and a
// finished result waits in the output register while the next request is
// taken. A load is written as it is taken and leaves the block idle. A build
// does an identity fill at one entry a cycle, then swaps each entry through
// the single write port of the permutation memory: read the value, scale it
// to a swap index, read both entries, write each back. An evaluation in D
// dimensions visits 2^D corners, each a chain of D permutation reads and one
// value read, each read an issue then a capture. Each of the 2^D-1 blends
// parks its lower input, then multiplies and adds; the result then moves to
// the output register once an earlier result there has been taken.
// Every value entry that a build or evaluation reads must be loaded first,
// and evaluations must follow a build; the tables have no reset value.
module lattice_value_noise #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: entry_index[7:0], entry_value[23:8], dimensions[25:24],
  //        coord_x[57:26], coord_y[89:58], coord_z[121:90], zero pad
  input  logic [127:0] in_tdata,
  // tuser: req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: noise_value[15:0]
  output logic [15:0]  out_tdata
);

  lvn_pkg::dp_cmd_t  cmd;
  lvn_pkg::dp_stat_t stat;

  lvn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req        (in_tuser),
    .dims_in    (in_tdata[lvn_pkg::DIM_LSB +: 2]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lvn_dpath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule

### rtl/lvn_checker.sv
// Port-level checker for lattice_value_noise, bound to the top level.
// Uses lvn_pkg for request codes.
module lvn_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [15:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an evaluation keeps the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == lvn_pkg::REQ_EVAL |=> !in_tready)
    else $error("request taken during evaluation");

  // a load completes at once
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == lvn_pkg::REQ_LOAD |=> in_tready)
    else $error("load left the block busy");

  // a new result only follows a busy period
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work");

endmodule

bind lattice_value_noise lvn_checker u_lvn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sv/tb.sv
// Testbench for lattice_value_noise: directed and random load, build and evaluate requests.
// Depends on lvn_pkg and the lattice_value_noise RTL; contains its own noise predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Noise predictor and expected-noise queue
  class noise_scoreboard;
    bit [15:0] values[ENTRIES];
    bit [7:0]  perm[ENTRIES];
    bit [15:0] pending_noise[$];
    int        mismatches;
    int        checked;

    function automatic longint hash_at(longint i);
      longint a;
      a = (i < 0) ? -i : i;
      return longint'(perm[a % ENTRIES]);
    endfunction

    function automatic longint value_at(longint i);
      return longint'(values[i % ENTRIES]);
    endfunction

    function automatic longint weight_of(longint t);
      longint t2, t3, w;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      w = 65536 + 2 * t3 - 3 * t2;
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
      return w;
    endfunction

    function automatic longint mix(longint lo, longint hi, longint w);
      longint d;
      d = (lo - hi) * w;
      return hi + (d >>> 16);
    endfunction

    function automatic longint corner_value(int dims, longint i, longint j, longint k);
      if (dims == 1) return value_at(hash_at(i));
      if (dims == 2) return value_at(hash_at(i + hash_at(j)));
      return value_at(hash_at(i) + hash_at(j + hash_at(k)));
    endfunction

    function automatic bit [15:0] noise_at(int dims, logic signed [31:0] c[3]);
      longint fl[3], w[3], vx[2], vy[2], vz[2];
      for (int d = 0; d < 3; d++) begin
        fl[d] = 0;
        w[d] = weight_of(0);
        if (d < dims) begin
          fl[d] = longint'(c[d]) >>> 16;
          w[d] = weight_of(longint'(c[d][15:0]));
        end
      end
      for (int a = 0; a < 2; a++) begin
        if (dims == 1) begin
          vx[a] = corner_value(1, fl[0] + a, 0, 0);
        end else begin
          for (int b = 0; b < 2; b++) begin
            if (dims == 2) begin
              vy[b] = corner_value(2, fl[0] + a, fl[1] + b, 0);
            end else begin
              for (int e = 0; e < 2; e++)
                vz[e] = corner_value(3, fl[0] + a, fl[1] + b, fl[2] + e);
              vy[b] = mix(vz[0], vz[1], w[2]);
            end
          end
          vx[a] = mix(vy[0], vy[1], w[1]);
        end
      end
      return 16'(mix(vx[0], vx[1], w[0]));
    endfunction

    function void note_request(logic [1:0] kind, logic [127:0] data);
      logic signed [31:0] c[3];
      int dims;
      bit [7:0] tmp;
      int s;
      if (kind == lvn_pkg::REQ_LOAD) begin
        values[data[7:0]] = data[23:8];
      end else if (kind == lvn_pkg::REQ_BUILD) begin
        for (int n = 0; n < ENTRIES; n++) perm[n] = 8'(n);
        for (int n = 0; n < ENTRIES; n++) begin
          s = int'((longint'(values[n]) * (ENTRIES - 1)) >> 16);
          tmp = perm[n];
          perm[n] = perm[s];
          perm[s] = tmp;
        end
      end else if (kind == lvn_pkg::REQ_EVAL) begin
        dims = int'(data[25:24]);
        if (dims == 0) dims = 1;
        c[0] = data[57:26];
        c[1] = data[89:58];
        c[2] = data[121:90];
        pending_noise.push_back(noise_at(dims, c));
      end
    endfunction

    function void check_noise(logic [15:0] got);
      bit [15:0] want;
      checked++;
      if (pending_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise result %h", got);
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("noise_value mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic in_tready, out_tvalid;
  logic [127:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic [15:0] out_tdata;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int idle_cycles = 0, requests = 0;
  noise_scoreboard sb = new();

  lattice_value_noise dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stalls and result checks
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_noise(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // tvalid stays high between back-to-back requests and drops only for idle cycles
  task automatic send_request(logic [1:0] kind, logic [127:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, data);
    requests++;
  endtask

  function automatic logic [127:0] eval_data(logic [1:0] dims, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
    logic [127:0] d;
    d = '0;
    d[25:24] = dims;
    d[57:26] = x;
    d[89:58] = y;
    d[121:90] = z;
    return d;
  endfunction

  task automatic load_entry(int idx, logic [15:0] v);
    logic [127:0] d;
    d = '0;
    d[7:0] = 8'(idx);
    d[23:8] = v;
    send_request(lvn_pkg::REQ_LOAD, d);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
      2: return {$urandom_range(1) ? 16'h8000 : 16'h7fff, 16'($urandom())};
      default: return 32'(int'($urandom_range(40)) - 20) << 16;
    endcase
  endfunction

  task automatic random_phase(int count);
    int k;
    logic [127:0] d;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 8) load_entry($urandom_range(255), 16'($urandom()));
      else if (k < 10) send_request(lvn_pkg::REQ_BUILD, '0);
      else if (k < 13) begin
        // unused request kind carries random noise
        d = {$urandom(), $urandom(), $urandom(), $urandom()};
        send_request(REQ_UNUSED, d);
      end else begin
        d = eval_data(2'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord());
        d[127:122] = 6'($urandom());
        d[7:0] = 8'($urandom());
        d[23:8] = 16'($urandom());
        send_request(lvn_pkg::REQ_EVAL, d);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // every entry written before any build or evaluation
    for (int i = 0; i < ENTRIES; i++)
      load_entry(i, (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : 16'($urandom()));
    send_request(lvn_pkg::REQ_BUILD, '0);
    // directed: extremes of coordinates, all dimension codes
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd0, 32'h8000_0000, 0, 0));
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd1, 32'h7fff_ffff, 0, 0));
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd1, 32'hffff_ffff, 0, 0));
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd1, 32'h0000_8000, 0, 0));
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd2, 32'h8000_0000, 32'h7fff_ffff, 0));
    send_request(lvn_pkg::REQ_EVAL, eval_data(2'd2, 32'hfffe_4000, 32'h0001_c000, 0));
    send_request(lvn_pkg::REQ_EVAL,
                 eval_data(2'd3, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    send_request(lvn_pkg::REQ_EVAL,
                 eval_data(2'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_request(lvn_pkg::REQ_EVAL,
                 eval_data(2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_request(REQ_UNUSED, '1);
    load_entry(0, 16'hffff);
    load_entry(255, 16'h0000);
    send_request(lvn_pkg::REQ_BUILD, '0);
    send_request(lvn_pkg::REQ_EVAL,
                 eval_data(2'd3, 32'h0012_3456, 32'hfedc_ba98, 32'h0000_ffff));
    // random phases under different flow control
    random_phase(60);
    send_idle_pct = 52;
    random_phase(60);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    random_phase(60);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    random_phase(60);
    in_tvalid <= 0;
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d noise results checked over four flow-control phases",
             requests, sb.checked);
    if (sb.mismatches == 0 && sb.pending_noise.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

### filelist.f
rtl/lvn_pkg.sv
rtl/lvn_ctrl.sv
rtl/lvn_dpath.sv
rtl/lattice_value_noise.sv
rtl/lvn_checker.sv
tb/sv/tb.sv
